[hw/rtl/lsp_pkg.sv]
// Package for the LIFO stack with palindrome check.
// Holds sizes, operation and status codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package lsp_pkg;

  localparam int DEPTH   = 8;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PAL  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic finish;
  } lsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pairs_done;
    logic              out_busy;
  } lsp_sts_t;

endpackage

[hw/rtl/lsp_if.sv]
// Valid/ready channel interfaces for the stack's input and result transactions.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

interface lsp_in_if
  import lsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface lsp_out_if
  import lsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;
  logic                     is_palindrome;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output pop_value, output status, output is_palindrome,
                  output depth, input ready);
  modport sink   (input valid, input pop_value, input status, input is_palindrome,
                  input depth, output ready);
endinterface

[hw/rtl/lifo_stack_with_palindrome_check.sv]
// LIFO stack of DEPTH signed 32-bit words with push, pop and a palindrome check;
// one result transaction for each input transaction, carrying the depth afterwards.
// Push, pop and the unused code pass through the idle, read and done states: the result
// is offered from the output register once the item is done, and the next input is taken
// when the block is back in idle. The palindrome check walks floor(depth/2) mirror
// pairs, reading one pair per pass through the read and compare states of the two-port word
// memory and comparing it in the next cycle. One item is in work at a time; a new item
// is accepted while the previous result still waits in the output register, and a
// stalled result holds the next one in its final state. Depends on lsp_pkg, lsp_if,
// lsp_ctrl and lsp_dp.
`timescale 1ns / 1ps

module lifo_stack_with_palindrome_check
  import lsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  lsp_in_if.sink   in_chan,
  lsp_out_if.source out_chan
);

  lsp_cmd_t cmd;
  lsp_sts_t sts;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_chan.func),
    .in_push_value     (in_chan.push_value),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_pop_value     (out_chan.pop_value),
    .out_status        (out_chan.status),
    .out_is_palindrome (out_chan.is_palindrome),
    .out_depth         (out_chan.depth)
  );

endmodule

[hw/rtl/lsp_ctrl.sv]
// Controller state machine of the stack: sequences load, memory reads,
// mirror compares and the final result. Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_ctrl
  import lsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lsp_sts_t sts,
  output lsp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (sts.func == FUNC_PAL && !sts.pairs_done) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_READ;
      end
      S_DONE: begin
        // Hold the finished result until the output register is free.
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/lsp_dp.sv]
// Datapath of the stack: word memory, element count, mirror-walk indexes,
// compare flag and the output register. Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_dp
  import lsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  lsp_cmd_t                 cmd,
  output lsp_sts_t                 sts,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [DATA_W-1:0] in_push_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_is_palindrome,
  output logic [DEPTH_W-1:0]       out_depth
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [FUNC_W-1:0]        func_r;
  logic [DATA_W-1:0]        value_r;
  logic [CNT_W-1:0]         lo_r;
  logic [CNT_W-1:0]         hi_r;
  logic [CNT_W-1:0]         pairs_r;
  logic                     match_r;
  logic [DATA_W-1:0]        rd_a_r;
  logic [DATA_W-1:0]        rd_b_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] pop_value_r;
  logic [STAT_W-1:0]        status_r;
  logic                     pal_r;
  logic [DEPTH_W-1:0]       depth_r;

  logic                     full;
  logic                     empty;
  logic                     wr_en;
  logic [DATA_W-1:0]        pop_value_nxt;
  logic [STAT_W-1:0]        status_nxt;
  logic                     pal_nxt;
  logic [CNT_W+DEPTH_W-1:0] count_ext;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    count_nxt     = count_r;
    pop_value_nxt = '0;
    status_nxt    = STAT_OK;
    pal_nxt       = 1'b0;
    wr_en         = 1'b0;
    case (func_r)
      FUNC_PUSH: begin
        if (full) begin
          status_nxt = STAT_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          count_nxt     = count_r - CNT_W'(1);
          pop_value_nxt = rd_b_r;
        end
      end
      FUNC_PAL: begin
        pal_nxt = match_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign count_ext = {{DEPTH_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and walk registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      value_r <= in_push_value;
      lo_r    <= '0;
      hi_r    <= count_r - CNT_W'(1);
      pairs_r <= count_r >> 1;
      match_r <= 1'b1;
    end
    if (cmd.step) begin
      if (rd_a_r != rd_b_r) begin
        match_r <= 1'b0;
      end
      lo_r    <= lo_r + CNT_W'(1);
      hi_r    <= hi_r - CNT_W'(1);
      pairs_r <= pairs_r - CNT_W'(1);
    end
    if (cmd.finish) begin
      pop_value_r <= pop_value_nxt;
      status_r    <= status_nxt;
      pal_r       <= pal_nxt;
      depth_r     <= count_ext[DEPTH_W-1:0];
    end
  end

  // Two registered read ports: the low and high mirror positions.
  // For a pop the high port addresses the top word.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a_r <= mem[lo_r[PTR_W-1:0]];
      rd_b_r <= mem[hi_r[PTR_W-1:0]];
    end
    if (cmd.finish && wr_en) begin
      mem[count_r[PTR_W-1:0]] <= value_r;
    end
  end

  assign sts.func       = func_r;
  assign sts.pairs_done = (pairs_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_pop_value     = pop_value_r;
  assign out_status        = status_r;
  assign out_is_palindrome = pal_r;
  assign out_depth         = depth_r;

endmodule

[hw/rtl/lsp_chk.sv]
// Port-level checker for the LIFO stack, bound to the top level.
// Depends on lsp_pkg and lifo_stack_with_palindrome_check.
`timescale 1ns / 1ps

module lsp_chk
  import lsp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_pop_value,
  input logic [STAT_W-1:0]        out_status,
  input logic                     out_is_palindrome,
  input logic [DEPTH_W-1:0]       out_depth
);

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(DEPTH % (1 << DEPTH_W));

  // A result must stay offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the previous item is in work");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OVERFLOW |-> out_depth == FULL_DEPTH)
    else $error("overflow reported on a stack that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_UNDERFLOW |-> out_depth == '0 && out_pop_value == '0)
    else $error("underflow result is inconsistent");

  a_pal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_palindrome |-> out_status == STAT_OK && out_pop_value == '0)
    else $error("palindrome result carries pop data or an error status");

endmodule

bind lifo_stack_with_palindrome_check lsp_chk u_lsp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_pop_value     (out_chan.pop_value),
  .out_status        (out_chan.status),
  .out_is_palindrome (out_chan.is_palindrome),
  .out_depth         (out_chan.depth)
);
